[src/loss_metric_accumulator_macros.svh]
`ifndef LOSS_METRIC_ACCUMULATOR_MACROS_SVH
`define LOSS_METRIC_ACCUMULATOR_MACROS_SVH

// same-cycle implication, checked on aclk outside reset
`define LMA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on aclk outside reset
`define LMA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lma_pkg.sv]
`default_nettype none

package lma_pkg;

    localparam int MUL_STEPS = 36;
    localparam int DIV_STEPS = 64;
    localparam int OPA_W     = 64;
    localparam int OPB_W     = 36;
    localparam int RES_W     = 72;
    localparam int STEP_W    = 7;
    localparam int TAB_W     = 30;

    localparam logic [STEP_W-1:0] MUL_LAST = STEP_W'(MUL_STEPS - 1);
    localparam logic [STEP_W-1:0] DIV_LAST = STEP_W'(DIV_STEPS - 1);

    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic signed [63:0] SUM_MAX  = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] MAPE_LIM = 64'sd92233720368547758;

    localparam logic [2:0] MODE_MSE  = 3'd0;
    localparam logic [2:0] MODE_MAE  = 3'd1;
    localparam logic [2:0] MODE_MAPE = 3'd2;
    localparam logic [2:0] MODE_BCE  = 3'd3;
    localparam logic [2:0] MODE_CCE  = 3'd4;
    localparam logic [2:0] MODE_ACC  = 3'd5;

    localparam logic REG_MODE  = 1'b0;
    localparam logic REG_FLOOR = 1'b1;

    typedef enum logic {
        OP_MUL = 1'b0,
        OP_DIV = 1'b1
    } arith_op_t;

    typedef struct packed {
        logic      start;
        arith_op_t op;
    } arith_req_t;

    // ln(1 + i/2^tbits) in Q30, bitwise squaring log2 times ln2
    function automatic logic [29:0] ln_entry(input int tbits, input int idx);
        logic [63:0] m;
        logic [63:0] l2;
        logic [63:0] prod;
        m  = (64'd1 << 30) + (64'(idx) << (30 - tbits));
        l2 = 64'd0;
        if (m >= (64'd1 << 31)) begin
            l2 = 64'd1 << 30;
        end else begin
            for (int bit_i = 1; bit_i <= 30; bit_i++) begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30)) begin
                    m  = m >> 1;
                    l2 = l2 | (64'd1 << (30 - bit_i));
                end
            end
        end
        prod = (l2 * {34'd0, LN2_Q30}) >> 30;
        return prod[29:0];
    endfunction

endpackage

`default_nettype wire

[src/lma_arith_unit.sv]
`default_nettype none

module lma_arith_unit (
    input  wire                                aclk,
    input  wire                                aresetn,
    input  lma_pkg::arith_req_t                req,
    input  wire  [lma_pkg::OPA_W-1:0]          arg_a,
    input  wire  [lma_pkg::OPB_W-1:0]          arg_b,
    output logic                               done,
    output logic [lma_pkg::RES_W-1:0]          result
);

    logic                              busy_reg, busy_next;
    logic                              done_reg, done_next;
    lma_pkg::arith_op_t                op_reg, op_next;
    logic [lma_pkg::STEP_W-1:0]        cnt_reg, cnt_next;
    logic [lma_pkg::RES_W-1:0]         acc_reg, acc_next;
    logic [lma_pkg::RES_W-1:0]         x_reg, x_next;
    logic [lma_pkg::OPB_W-1:0]         y_reg, y_next;
    logic [lma_pkg::OPB_W:0]           rem_sh;
    logic [lma_pkg::OPB_W+1:0]         diff;
    logic                              ge;
    logic                              last_step;

    always_comb begin
        rem_sh    = {acc_reg[lma_pkg::OPB_W-1:0], x_reg[lma_pkg::OPA_W-1]};
        diff      = {1'b0, rem_sh} - {2'b00, y_reg};
        ge        = ~diff[lma_pkg::OPB_W+1];
        last_step = (op_reg == lma_pkg::OP_MUL)
                  ? (cnt_reg == lma_pkg::MUL_LAST)
                  : (cnt_reg == lma_pkg::DIV_LAST);
        busy_next = busy_reg;
        done_next = 1'b0;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        if (req.start) begin
            busy_next = 1'b1;
            op_next   = req.op;
            cnt_next  = '0;
            acc_next  = '0;
            x_next    = {{(lma_pkg::RES_W-lma_pkg::OPA_W){1'b0}}, arg_a};
            y_next    = arg_b;
        end else if (busy_reg) begin
            cnt_next = cnt_reg + 1'b1;
            if (op_reg == lma_pkg::OP_MUL) begin
                if (y_reg[0]) begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[lma_pkg::RES_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[lma_pkg::OPB_W-1:1]};
            end else begin
                acc_next = {{(lma_pkg::RES_W-lma_pkg::OPB_W-1){1'b0}},
                            ge ? diff[lma_pkg::OPB_W:0] : rem_sh};
                x_next   = {x_reg[lma_pkg::RES_W-2:0], ge};
            end
            if (last_step) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        op_reg  <= op_next;
        cnt_reg <= cnt_next;
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign done   = done_reg;
    assign result = (op_reg == lma_pkg::OP_MUL) ? acc_reg
                  : {{(lma_pkg::RES_W-lma_pkg::OPA_W){1'b0}}, x_reg[lma_pkg::OPA_W-1:0]};

endmodule

`default_nettype wire

[src/lma_ln_table.sv]
`default_nettype none

module lma_ln_table #(
    parameter int TBITS = 8
) (
    input  wire  [TBITS-1:0]            idx,
    output logic [lma_pkg::TAB_W-1:0]   lo_val,
    output logic [lma_pkg::TAB_W-1:0]   hi_val
);

    localparam int TAB_LEN = (1 << TBITS) + 1;

    logic [lma_pkg::TAB_W-1:0] tab [TAB_LEN];

    for (genvar gi = 0; gi < TAB_LEN; gi++) begin : g_tab
        localparam logic [lma_pkg::TAB_W-1:0] VAL = lma_pkg::ln_entry(TBITS, gi);
        assign tab[gi] = VAL;
    end

    assign lo_val = tab[{1'b0, idx}];
    assign hi_val = tab[{1'b0, idx} + 1'b1];

endmodule

`default_nettype wire

[src/loss_metric_accumulator.sv]
// Channel   | Ports                         | Contents
// ----------+-------------------------------+------------------------------------------
// input     | s_tvalid/s_tready/s_tdata/tlast| pred_value, real_value, last_item
// result    | m_tvalid/m_tready/m_tdata/tuser| metric_value, saturated
// config    | psel/penable/pwrite/paddr/...  | metric_mode @0x0, clip_floor @0x4
//
// Work per item: mae, accuracy and unused modes use no unit step; mse one multiply; mape
// one divide; cce one log operand and bce two, each normalized by shifts and then multiplied.
// An item with tlast adds a divide for the mean, plus any wait on m_tready.
// All multiplies (36 steps) and divides (64 steps) share one radix-2 unit.
// Reset clears the sum, count, flags and registers to their reset values.
// s_tready is low while an item is in work; an unread result holds off the
// next mean, and with it s_tready, until m_tready drains it.
`default_nettype none

module loss_metric_accumulator #(
    parameter int FRAC_BITS      = 24,
    parameter int MAX_ITEMS      = 65536,
    parameter int LOG_TABLE_BITS = 8
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // [31:0] pred_value, [63:32] real_value
    input  wire         s_tlast,
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [31:0] m_tdata,   // [31:0] metric_value
    output logic [0:0]  m_tuser,   // [0] saturated
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

`include "loss_metric_accumulator_macros.svh"

    localparam int CNT_W = $clog2(MAX_ITEMS + 1);
    localparam int LB    = LOG_TABLE_BITS;
    localparam logic signed [33:0] ONE_S  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] HALF_S = 34'sd1 <<< (FRAC_BITS - 1);
    localparam logic [4:0] SH_OFF = 5'(30 - FRAC_BITS);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_TERM  = 11'b000_0000_0010,
        S_MSE_W = 11'b000_0000_0100,
        S_MAPE_W= 11'b000_0000_1000,
        S_NORM  = 11'b000_0001_0000,
        S_LN_W  = 11'b000_0010_0000,
        S_CE_W  = 11'b000_0100_0000,
        S_ACC   = 11'b000_1000_0000,
        S_SCALE = 11'b001_0000_0000,
        S_DIV_W = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [2:0]               mode_reg;
    logic [23:0]              floor_reg;
    logic signed [31:0]       p_reg, r_reg;
    logic                     last_reg;
    logic                     pass_reg, pass_next;
    logic signed [33:0]       c_reg, c_next;
    logic [30:0]              m_reg, m_next;
    logic [4:0]               sh_reg, sh_next;
    logic [29:0]              lna_reg, lna_next;
    logic [4:0]               nsh_reg, nsh_next;
    logic                     neg_reg, neg_next;
    logic signed [63:0]       term_reg, term_next;
    logic signed [63:0]       sum_reg, sum_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic                     sat_reg, sat_next;
    logic                     rneg_reg, rneg_next;
    logic [31:0]              oval_reg, oval_next;
    logic                     osat_reg, osat_next;
    logic                     mval_reg, mval_next;
    logic [31:0]              mdat_reg, mdat_next;
    logic                     musr_reg, musr_next;

    lma_pkg::arith_req_t      req;
    logic [63:0]              arg_a;
    logic [35:0]              arg_b;
    logic                     unit_done;
    logic [71:0]              unit_res;
    logic [29:0]              tab_lo, tab_hi;

    logic                     in_acc, cfg_wr, unit_wait;
    logic signed [32:0]       d;
    logic [32:0]              ad;
    logic signed [33:0]       e, ce, c1, chi, den, coef;
    logic signed [30:0]       lnm;
    logic [35:0]              nsh_ln;
    logic signed [37:0]       ln_total, ln_val;
    logic [35:0]              coef_mag, ln_mag;
    logic signed [72:0]       prod_s, part;
    logic signed [64:0]       sum65;
    logic signed [63:0]       s_val;
    logic                     s_sat, real_one, match;
    logic [63:0]              s_mag;

    lma_arith_unit u_arith (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (req),
        .arg_a   (arg_a),
        .arg_b   (arg_b),
        .done    (unit_done),
        .result  (unit_res)
    );

    lma_ln_table #(.TBITS(LB)) u_ln_table (
        .idx    (m_reg[29 -: LB]),
        .lo_val (tab_lo),
        .hi_val (tab_hi)
    );

    assign cfg_wr = psel & penable & pwrite & pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == lma_pkg::REG_FLOOR) ? {8'd0, floor_reg} : {29'd0, mode_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= lma_pkg::MODE_MSE;
            floor_reg <= 24'd2;
        end else if (cfg_wr) begin
            if (paddr[2] == lma_pkg::REG_MODE) begin
                mode_reg <= pwdata[2:0];
            end else begin
                floor_reg <= pwdata[23:0];
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign in_acc   = s_tvalid & s_tready;
    assign unit_wait = (state_reg == S_MSE_W) || (state_reg == S_MAPE_W)
                    || (state_reg == S_LN_W) || (state_reg == S_CE_W)
                    || (state_reg == S_DIV_W);

    always_comb begin
        d   = 33'(p_reg) - 33'(r_reg);
        ad  = d[32] ? 33'(-d) : 33'(d);
        e   = (floor_reg == 24'd0) ? 34'sd1 : 34'(signed'({1'b0, floor_reg}));
        ce  = (e > ONE_S - 34'sd1) ? ONE_S - 34'sd1 : e;
        c1  = (34'(p_reg) > ce) ? 34'(p_reg) : ce;
        chi = ONE_S - ce;
        den = (34'(r_reg) > e) ? 34'(r_reg) : e;
        real_one = 34'(r_reg) >= HALF_S;
        match = real_one ? (34'(p_reg) >= HALF_S && 34'(p_reg) < ONE_S + HALF_S)
                         : (34'(p_reg) > -HALF_S && 34'(p_reg) < HALF_S);
        lnm      = 31'(signed'({1'b0, lna_reg})) + 31'(unit_res >> (30 - LB));
        nsh_ln   = 36'(nsh_reg) * 36'(lma_pkg::LN2_Q30);
        ln_total = 38'(lnm) - 38'(signed'({1'b0, nsh_ln}));
        ln_val   = ln_total >>> (30 - FRAC_BITS);
        coef     = pass_reg ? ONE_S - 34'(r_reg) : 34'(r_reg);
        coef_mag = coef[33] ? 36'(-coef) : 36'(coef);
        ln_mag   = ln_val[37] ? 36'(-ln_val) : 36'(ln_val);
        prod_s   = neg_reg ? -signed'({1'b0, unit_res}) : signed'({1'b0, unit_res});
        part     = prod_s >>> FRAC_BITS;
        sum65    = 65'(sum_reg) + 65'(term_reg);
        s_sat    = 1'b0;
        s_val    = sum_reg;
        if (mode_reg == lma_pkg::MODE_BCE || mode_reg == lma_pkg::MODE_CCE) begin
            s_val = -sum_reg;
        end else if (mode_reg == lma_pkg::MODE_MAPE) begin
            if (sum_reg > lma_pkg::MAPE_LIM) begin
                s_val = lma_pkg::SUM_MAX;
                s_sat = 1'b1;
            end else if (sum_reg < -lma_pkg::MAPE_LIM) begin
                s_val = -lma_pkg::SUM_MAX;
                s_sat = 1'b1;
            end else begin
                s_val = (sum_reg <<< 6) + (sum_reg <<< 5) + (sum_reg <<< 2);
            end
        end
        s_mag = s_val[63] ? 64'(-s_val) : 64'(s_val);
    end

    always_comb begin
        state_next = state_reg;
        pass_next  = pass_reg;
        c_next     = c_reg;
        m_next     = m_reg;
        sh_next    = sh_reg;
        lna_next   = lna_reg;
        nsh_next   = nsh_reg;
        neg_next   = neg_reg;
        term_next  = term_reg;
        sum_next   = sum_reg;
        cnt_next   = cnt_reg;
        ovf_next   = ovf_reg;
        sat_next   = sat_reg;
        rneg_next  = rneg_reg;
        oval_next  = oval_reg;
        osat_next  = osat_reg;
        mval_next  = mval_reg;
        mdat_next  = mdat_reg;
        musr_next  = musr_reg;
        req.start  = 1'b0;
        req.op     = lma_pkg::OP_MUL;
        arg_a      = '0;
        arg_b      = '0;
        if (mval_reg && m_tready) begin
            mval_next = 1'b0;
        end
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    state_next = S_TERM;
                end
            end
            S_TERM: begin
                term_next = '0;
                case (mode_reg)
                    lma_pkg::MODE_MSE: begin
                        req.start  = 1'b1;
                        arg_a      = 64'(ad);
                        arg_b      = 36'(ad);
                        state_next = S_MSE_W;
                    end
                    lma_pkg::MODE_MAE: begin
                        term_next  = 64'(ad);
                        state_next = S_ACC;
                    end
                    lma_pkg::MODE_MAPE: begin
                        req.start  = 1'b1;
                        req.op     = lma_pkg::OP_DIV;
                        arg_a      = 64'(ad) << FRAC_BITS;
                        arg_b      = 36'(den);
                        state_next = S_MAPE_W;
                    end
                    lma_pkg::MODE_BCE, lma_pkg::MODE_CCE: begin
                        c_next     = (c1 > chi) ? chi : c1;
                        m_next     = 31'((c1 > chi) ? chi : c1);
                        sh_next    = '0;
                        pass_next  = 1'b0;
                        state_next = S_NORM;
                    end
                    lma_pkg::MODE_ACC: begin
                        term_next  = match ? 64'(ONE_S) : 64'sd0;
                        state_next = S_ACC;
                    end
                    default: begin
                        state_next = S_ACC;
                    end
                endcase
            end
            S_MSE_W: begin
                if (unit_done) begin
                    term_next  = 64'(unit_res >> FRAC_BITS);
                    state_next = S_ACC;
                end
            end
            S_MAPE_W: begin
                if (unit_done) begin
                    term_next  = 64'(unit_res);
                    state_next = S_ACC;
                end
            end
            S_NORM: begin
                if (m_reg[30]) begin
                    req.start  = 1'b1;
                    arg_a      = 64'(tab_hi - tab_lo);
                    arg_b      = 36'(m_reg[29-LB:0]);
                    lna_next   = tab_lo;
                    nsh_next   = sh_reg - SH_OFF;
                    state_next = S_LN_W;
                end else begin
                    m_next  = {m_reg[29:0], 1'b0};
                    sh_next = sh_reg + 1'b1;
                end
            end
            S_LN_W: begin
                if (unit_done) begin
                    req.start  = 1'b1;
                    arg_a      = 64'(coef_mag);
                    arg_b      = ln_mag;
                    neg_next   = coef[33] ^ ln_val[37];
                    state_next = S_CE_W;
                end
            end
            S_CE_W: begin
                if (unit_done) begin
                    term_next = term_reg + 64'(part);
                    if (mode_reg == lma_pkg::MODE_BCE && !pass_reg) begin
                        pass_next  = 1'b1;
                        m_next     = 31'(ONE_S - c_reg);
                        sh_next    = '0;
                        state_next = S_NORM;
                    end else begin
                        state_next = S_ACC;
                    end
                end
            end
            S_ACC: begin
                if (sum65 > 65'(lma_pkg::SUM_MAX)) begin
                    sum_next = lma_pkg::SUM_MAX;
                    ovf_next = 1'b1;
                end else if (sum65 < -65'(lma_pkg::SUM_MAX)) begin
                    sum_next = -lma_pkg::SUM_MAX;
                    ovf_next = 1'b1;
                end else begin
                    sum_next = 64'(sum65);
                end
                if (cnt_reg < CNT_W'(MAX_ITEMS)) begin
                    cnt_next = cnt_reg + 1'b1;
                end else begin
                    ovf_next = 1'b1;
                end
                state_next = last_reg ? S_SCALE : S_IDLE;
            end
            S_SCALE: begin
                req.start  = 1'b1;
                req.op     = lma_pkg::OP_DIV;
                arg_a      = s_mag;
                arg_b      = 36'(cnt_reg);
                sat_next   = ovf_reg | s_sat;
                rneg_next  = s_val[63];
                state_next = S_DIV_W;
            end
            S_DIV_W: begin
                if (unit_done) begin
                    osat_next = sat_reg;
                    if (rneg_reg) begin
                        if (unit_res[63:0] > 64'h8000_0000) begin
                            oval_next = 32'h8000_0000;
                            osat_next = 1'b1;
                        end else begin
                            oval_next = 32'(-unit_res[31:0]);
                        end
                    end else begin
                        if (unit_res[63:0] > 64'h7FFF_FFFF) begin
                            oval_next = 32'h7FFF_FFFF;
                            osat_next = 1'b1;
                        end else begin
                            oval_next = unit_res[31:0];
                        end
                    end
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!mval_reg || m_tready) begin
                    mval_next  = 1'b1;
                    mdat_next  = oval_reg;
                    musr_next  = osat_reg;
                    sum_next   = '0;
                    cnt_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            sum_reg   <= '0;
            cnt_reg   <= '0;
            ovf_reg   <= 1'b0;
            mval_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            sum_reg   <= sum_next;
            cnt_reg   <= cnt_next;
            ovf_reg   <= ovf_next;
            mval_reg  <= mval_next;
        end
        if (in_acc) begin
            p_reg    <= signed'(s_tdata[31:0]);
            r_reg    <= signed'(s_tdata[63:32]);
            last_reg <= s_tlast;
        end
        pass_reg <= pass_next;
        c_reg    <= c_next;
        m_reg    <= m_next;
        sh_reg   <= sh_next;
        lna_reg  <= lna_next;
        nsh_reg  <= nsh_next;
        neg_reg  <= neg_next;
        term_reg <= term_next;
        sat_reg  <= sat_next;
        rneg_reg <= rneg_next;
        oval_reg <= oval_next;
        osat_reg <= osat_next;
        mdat_reg <= mdat_next;
        musr_reg <= musr_next;
    end

    assign m_tvalid = mval_reg;
    assign m_tdata  = mdat_reg;
    assign m_tuser  = musr_reg;

    `LMA_ASSERT_NXT(a_busy_after_item, in_acc, !s_tready, "input taken while item in work")
    `LMA_ASSERT_IMP(a_count_nonzero, state_reg == S_SCALE, cnt_reg != '0, "mean of empty set")
    `LMA_ASSERT_IMP(a_done_when_waiting, unit_done, unit_wait, "unit result unexpected")
    `LMA_ASSERT_IMP(a_sum_in_range, 1'b1, sum_reg != {1'b1, 63'd0}, "sum left range")

endmodule

`default_nettype wire

[tb/testbench.sv]
`default_nettype none

module testbench;

    localparam int FB = 24;
    localparam int TBITS = 8;
    localparam int CAP = 65536;
    localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
    localparam logic signed [63:0] TOP = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] ONE32 = 32'(ONE);
    localparam logic [2:0] ADDR_MODE  = {lma_pkg::REG_MODE, 2'b00};
    localparam logic [2:0] ADDR_FLOOR = {lma_pkg::REG_FLOOR, 2'b00};

    typedef struct {
        logic [31:0] pred;
        logic [31:0] real_v;
        logic        last;
    } pair_t;

    typedef struct {
        logic [31:0] metric;
        logic        sat;
    } mean_t;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        s_tvalid = 0;
    wire         s_tready;
    logic [63:0] s_tdata = 0;
    logic        s_tlast = 0;
    wire         m_tvalid;
    logic        m_tready = 0;
    wire  [31:0] m_tdata;
    wire  [0:0]  m_tuser;
    logic        psel = 0;
    logic        penable = 0;
    logic        pwrite = 0;
    logic [2:0]  paddr = 0;
    logic [31:0] pwdata = 0;
    wire  [31:0] prdata;
    wire         pready;

    loss_metric_accumulator dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always #2 aclk = ~aclk;

    pair_t pending[$];
    mean_t means_due[$];
    int    errors = 0;
    int    snd_idle = 6;
    int    rcv_idle = 66;
    bit    squeeze_go = 0;
    bit    squeeze_done = 0;
    int    hold_cnt = 0;

    logic [63:0]        ln_tab[0:(1<<TBITS)];
    logic [2:0]         mode_reg = lma_pkg::MODE_MSE;
    logic [23:0]        floor_reg = 24'd2;
    logic signed [63:0] acc_sum = 0;
    int                 acc_count = 0;
    bit                 acc_ovf = 0;

    initial begin
        logic [63:0] m;
        logic [63:0] l2;
        for (int i = 0; i <= (1 << TBITS); i++) begin
            m = (64'd1 << 30) + (64'(i) << (30 - TBITS));
            l2 = 0;
            if (m >= (64'd1 << 31)) begin
                l2 = 64'd1 << 30;
            end else begin
                for (int b = 1; b <= 30; b++) begin
                    m = (m * m) >> 30;
                    if (m >= (64'd2 << 30)) begin
                        m = m >> 1;
                        l2 |= 64'd1 << (30 - b);
                    end
                end
            end
            ln_tab[i] = (l2 * 64'd744261118) >> 30;
        end
    end

    function automatic logic signed [63:0] ln_fix(logic [63:0] q);
        int k;
        logic [63:0] f30, idx, rem;
        logic signed [63:0] a, b, lnm, total;
        k = 0;
        while (k < 62 && (q >> (k + 1)) != 0) k++;
        f30 = (q - (64'd1 << k)) << (30 - k);
        idx = f30 >> (30 - TBITS);
        rem = f30 & ((64'd1 << (30 - TBITS)) - 1);
        a = ln_tab[idx];
        b = ln_tab[idx + 1];
        lnm = a + 64'((64'(b - a) * rem) >> (30 - TBITS));
        total = 64'(k - FB) * 64'sd744261118 + lnm;
        return total >>> (30 - FB);
    endfunction

    function automatic logic signed [63:0] mul_fix(logic signed [63:0] a, logic signed [63:0] b);
        logic signed [127:0] prod;
        prod = 128'(a) * 128'(b);
        return 64'(prod >>> FB);
    endfunction

    function automatic logic signed [63:0] pair_loss(logic signed [63:0] p, logic signed [63:0] r);
        logic signed [63:0] d, e, den, ce, c, t, half;
        logic [63:0] ad;
        bit hit;
        d = p - r;
        ad = d < 0 ? -d : d;
        e = floor_reg;
        if (e < 1) e = 1;
        half = ONE / 2;
        case (mode_reg)
            lma_pkg::MODE_MSE: return (ad * ad) >> FB;
            lma_pkg::MODE_MAE: return ad;
            lma_pkg::MODE_MAPE: begin
                den = r > e ? r : e;
                return (ad << FB) / 64'(den);
            end
            lma_pkg::MODE_BCE, lma_pkg::MODE_CCE: begin
                ce = e > ONE - 1 ? ONE - 1 : e;
                c = p > ce ? p : ce;
                if (c > ONE - ce) c = ONE - ce;
                t = mul_fix(r, ln_fix(c));
                if (mode_reg == lma_pkg::MODE_BCE) t += mul_fix(ONE - r, ln_fix(ONE - c));
                return t;
            end
            lma_pkg::MODE_ACC: begin
                hit = (r >= half) ? (p >= half && p < ONE + half) : (p > -half && p < half);
                return hit ? ONE : 0;
            end
            default: return 0;
        endcase
    endfunction

    task automatic accumulate(logic [31:0] pv, logic [31:0] rv, logic last);
        logic signed [127:0] wide;
        logic signed [63:0] s;
        logic [63:0] mag;
        mean_t res;
        wide = 128'(acc_sum) + 128'(pair_loss(64'(signed'(pv)), 64'(signed'(rv))));
        if (wide > 128'(TOP)) begin
            acc_sum = TOP; acc_ovf = 1;
        end else if (wide < -128'(TOP)) begin
            acc_sum = -TOP; acc_ovf = 1;
        end else begin
            acc_sum = 64'(wide);
        end
        if (acc_count < CAP) acc_count++;
        else acc_ovf = 1;
        if (!last) return;
        res.sat = acc_ovf;
        s = acc_sum;
        if (mode_reg == lma_pkg::MODE_BCE || mode_reg == lma_pkg::MODE_CCE) begin
            s = -s;
        end else if (mode_reg == lma_pkg::MODE_MAPE) begin
            if (s > TOP / 100) begin
                s = TOP; res.sat = 1;
            end else if (s < -(TOP / 100)) begin
                s = -TOP; res.sat = 1;
            end else begin
                s = s * 100;
            end
        end
        mag = 64'(s < 0 ? -s : s) / 64'(acc_count);
        if (s < 0) begin
            if (mag > 64'h8000_0000) begin
                res.metric = 32'h8000_0000; res.sat = 1;
            end else begin
                res.metric = 32'(-mag);
            end
        end else begin
            if (mag > 64'h7FFF_FFFF) begin
                res.metric = 32'h7FFF_FFFF; res.sat = 1;
            end else begin
                res.metric = mag[31:0];
            end
        end
        means_due.push_back(res);
        acc_sum = 0;
        acc_count = 0;
        acc_ovf = 0;
    endtask

    always @(posedge aclk) begin
        pair_t it;
        if (!aresetn) begin
            s_tvalid <= 0;
        end else begin
            if (s_tvalid && s_tready) accumulate(s_tdata[31:0], s_tdata[63:32], s_tlast);
            if (!s_tvalid || s_tready) begin
                if (pending.size() > 0 && $urandom_range(0, 99) >= snd_idle) begin
                    it = pending.pop_front();
                    s_tvalid <= 1;
                    s_tdata <= {it.real_v, it.pred};
                    s_tlast <= it.last;
                end else begin
                    s_tvalid <= 0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        mean_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (means_due.size() == 0) begin
                $error("result with none expected: metric_value %h", m_tdata);
                errors++;
            end else begin
                want = means_due.pop_front();
                if (m_tdata !== want.metric) begin
                    $error("metric_value expected %h actual %h", want.metric, m_tdata);
                    errors++;
                end
                if (m_tuser[0] !== want.sat) begin
                    $error("saturated expected %b actual %b", want.sat, m_tuser[0]);
                    errors++;
                end
            end
        end
        if (squeeze_go && !squeeze_done) begin
            squeeze_done <= 1;
            hold_cnt <= 3000;
            m_tready <= 0;
        end else if (hold_cnt > 0) begin
            hold_cnt <= hold_cnt - 1;
            m_tready <= 0;
        end else begin
            m_tready <= $urandom_range(0, 99) >= rcv_idle;
        end
    end

    task automatic push_pair(logic [31:0] p, logic [31:0] r, logic last);
        pair_t it;
        it.pred = p;
        it.real_v = r;
        it.last = last;
        pending.push_back(it);
    endtask

    task automatic settle();
        while (pending.size() != 0 || s_tvalid || means_due.size() != 0) @(posedge aclk);
        repeat (600) @(posedge aclk);
    endtask

    task automatic reg_write(logic [2:0] addr, logic [31:0] val);
        @(posedge aclk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= addr; pwdata <= val;
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (addr == ADDR_MODE) mode_reg = val[2:0];
        else floor_reg = val[23:0];
    endtask

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return $urandom_range(0, ONE32);
            2: return ONE32 / 2 + $urandom_range(0, 8) - 4;
            3: case ($urandom_range(0, 6))
                0: return 32'h8000_0000;
                1: return 32'h7FFF_FFFF;
                2: return 0;
                3: return ONE32;
                4: return ONE32 - 1;
                5: return 1;
                default: return 32'hFFFF_FFFF;
            endcase
            default: return $urandom_range(0, 4 * ONE32) - 2 * ONE32;
        endcase
    endfunction

    function automatic logic [31:0] pick_floor();
        case ($urandom_range(0, 6))
            0: return 0;
            1: return 1;
            2: return ONE32 - 1;
            3: return ONE32;
            4: return 24'hFF_FFFF;
            5: return $urandom_range(1, 4096);
            default: return $urandom & 24'hFF_FFFF;
        endcase
    endfunction

    task automatic rand_block(int sets);
        int n;
        reg_write(ADDR_MODE, $urandom_range(0, 9) == 0 ? $urandom_range(6, 7)
                                                         : $urandom_range(0, 5));
        reg_write(ADDR_FLOOR, pick_floor());
        for (int s = 0; s < sets; s++) begin
            n = $urandom_range(0, 3) == 0 ? $urandom_range(5, 12) : $urandom_range(1, 4);
            for (int i = 0; i < n; i++) begin
                if ($urandom_range(0, 19) == 0)
                    push_pair($urandom, $urandom, i == n - 1);
                else
                    push_pair(pick_val(), pick_val(), i == n - 1);
            end
        end
        settle();
    endtask

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        for (int md = 0; md < 8; md++) begin
            reg_write(ADDR_MODE, md);
            push_pair(32'h7FFF_FFFF, 32'h8000_0000, 1);
            push_pair(32'h8000_0000, ONE32 / 2, 0);
            push_pair(ONE32 / 2, ONE32, 1);
            settle();
        end
        reg_write(ADDR_FLOOR, 0);
        reg_write(ADDR_MODE, lma_pkg::MODE_BCE);
        push_pair(0, ONE32 + 5, 1);
        settle();
        reg_write(ADDR_FLOOR, 24'hFF_FFFF);
        push_pair(ONE32 - 1, 32'hFFF0_0000, 1);
        settle();
        reg_write(ADDR_FLOOR, 2);
        reg_write(ADDR_MODE, lma_pkg::MODE_MSE);
        push_pair(ONE32, 0, 0);
        push_pair(3 * ONE32, ONE32, 0);
        settle();
        reg_write(ADDR_MODE, lma_pkg::MODE_CCE);
        push_pair(ONE32 / 4, ONE32, 1);
        settle();

        for (int ph = 0; ph < 3; ph++) begin
            snd_idle = ph == 0 ? 6 : (ph == 1 ? 66 : 0);
            rcv_idle = ph == 0 ? 66 : (ph == 1 ? 6 : 0);
            if (ph == 2) begin
                reg_write(ADDR_MODE, lma_pkg::MODE_MAE);
                for (int i = 0; i < 60; i++) push_pair(pick_val(), pick_val(), i % 3 == 2);
                squeeze_go = 1;
                settle();
                reg_write(ADDR_MODE, lma_pkg::MODE_MAPE);
                reg_write(ADDR_FLOOR, 1);
                for (int i = 0; i < 200; i++) push_pair(32'h7FFF_FFFF, 32'h8000_0000, i == 199);
                settle();
            end
            for (int b = 0; b < 18; b++) rand_block(6);
        end

        settle();
        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #100000000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

`default_nettype wire
